// ===== rtl/bgc_pkg.sv =====
// package for the bidirectional gate counter: constants, types and states
`default_nettype none
package bgc_pkg;

  localparam int GATES_DEF = 32;

  localparam int FACTOR_W = 4;
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 4'd4;

  localparam int CFG_AW = 3;
  localparam logic REG_FACTOR = 1'b0;

  localparam int IN_DW = 40;
  localparam int OUT_DW = 136;

  localparam int DIV_CW = 6;
  localparam logic [DIV_CW-1:0] DIV_STEPS_PASS = 6'd32;
  localparam logic [DIV_CW-1:0] DIV_STEPS_AVG = 6'd48;

  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic              start;
    logic [DIV_CW-1:0] steps;
    logic [47:0]       dividend;
    logic [31:0]       divisor;
  } bgc_div_req_t;

  typedef struct packed {
    logic        en;
    logic        a_lat;
    logic        b_lat;
    logic [31:0] start;
  } bgc_store_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_CMP,
    ST_DIV,
    ST_APPLY,
    ST_FINISH
  } bgc_state_t;

endpackage
`default_nettype wire

// ===== rtl/bgc_div.sv =====
// shared restoring divider, one quotient bit per cycle
`default_nettype none
module bgc_div (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire bgc_pkg::bgc_div_req_t req_i,
  output logic                     done_o,
  output logic [47:0]              quot_o
);
  import bgc_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [47:0]       dvd_r;
  logic [31:0]       dvs_r;
  logic [31:0]       rem_r;
  logic [47:0]       q_r;

  logic [32:0] trial;
  logic        ge;
  logic [32:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, dvd_r[47]};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? (trial - {1'b0, dvs_r}) : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req_i.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req_i.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_i.start) begin
      dvd_r <= req_i.dividend;
      dvs_r <= req_i.divisor;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[46:0], 1'b0};
      rem_r <= rem_nxt[31:0];
      q_r   <= {q_r[46:0], ge};
    end
  end

  assign done_o = done_r;
  assign quot_o = q_r;

endmodule
`default_nettype wire

// ===== rtl/bgc_gate_store.sv =====
// per-gate beam latches and passage start time memory
`default_nettype none
module bgc_gate_store #(
  parameter int GATES = bgc_pkg::GATES_DEF,
  localparam int GW = (GATES > 1) ? $clog2(GATES) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  rd_en_i,
  input  wire logic [GW-1:0]         rd_addr_i,
  input  wire bgc_pkg::bgc_store_wr_t wr_i,
  input  wire logic [GW-1:0]         wr_addr_i,
  output logic                       a_lat_o,
  output logic                       b_lat_o,
  output logic [31:0]                start_o
);
  import bgc_pkg::*;

  logic [GATES-1:0] a_lat_r;
  logic [GATES-1:0] b_lat_r;
  logic [31:0]      start_mem [GATES];
  logic             a_q_r;
  logic             b_q_r;
  logic [31:0]      start_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_lat_r <= '0;
      b_lat_r <= '0;
    end else if (wr_i.en) begin
      a_lat_r[wr_addr_i] <= wr_i.a_lat;
      b_lat_r[wr_addr_i] <= wr_i.b_lat;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_i.en) begin
      start_mem[wr_addr_i] <= wr_i.start;
    end
    if (rd_en_i) begin
      start_q_r <= start_mem[rd_addr_i];
      a_q_r     <= a_lat_r[rd_addr_i];
      b_q_r     <= b_lat_r[rd_addr_i];
    end
  end

  assign a_lat_o = a_q_r;
  assign b_lat_o = b_q_r;
  assign start_o = start_q_r;

endmodule
`default_nettype wire

// ===== rtl/bidirectional_gate_counter_unit.sv =====
// top level of the bidirectional gate counter with sequencer and totals
// a sample completing no passage goes EVAL to FINISH; FINISH waits for a free output
// a passage runs EVAL, CMP, DIV, APPLY, FINISH; 32 divider steps if long, 48 if not
// one sample at a time: the next is accepted only after the last result is loaded
// the shared restoring divider produces one quotient bit per cycle
// synchronous active-low reset clears latches, totals and average; factor resets to 4
`default_nettype none
module bidirectional_gate_counter_unit #(
  parameter int GATES = bgc_pkg::GATES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // gate_index[4:0], beam_a[5], beam_b[6], now_ms[38:7], zero [39]
  input  wire logic [bgc_pkg::IN_DW-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // in_count[31:0], out_count[63:32], inside_count[95:64],
  // mean_duration[127:96], count_changed[128], zero [135:129]
  output logic [bgc_pkg::OUT_DW-1:0]      out_tdata,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [bgc_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]                cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);
  import bgc_pkg::*;

  localparam int GW = (GATES > 1) ? $clog2(GATES) : 1;

  bgc_state_t state_r, state_nxt;

  logic [FACTOR_W-1:0] factor_r;

  logic [4:0]  gate_r;
  logic        a_r;
  logic        b_r;
  logic [31:0] now_r;
  logic        in_range_r;
  logic [31:0] dur_r, dur_nxt;
  logic        long_r;

  logic [31:0] in_tot_r, in_tot_nxt;
  logic [31:0] out_tot_r, out_tot_nxt;
  logic [31:0] single_r;
  logic [47:0] sum_r;
  logic [31:0] avg_r;
  logic [31:0] prev_r;

  logic              out_valid_r;
  logic [OUT_DW-1:0] out_data_r;

  logic          accept;
  logic          cfg_wr;
  logic          store_rd;
  bgc_store_wr_t store_wr;
  logic          st_a, st_b;
  logic [31:0]   st_start;
  bgc_div_req_t  div_req;
  logic          div_done;
  logic [47:0]   div_q;

  logic        la, lb, pass;
  logic [31:0] st_new;
  logic [35:0] limit;
  logic        is_long;
  logic [31:0] single_nxt;
  logic [48:0] sum_ext;
  logic [47:0] sum_nxt;
  logic [31:0] q_sat;
  logic [31:0] n_cnt;
  logic [32:0] add_ext;
  logic [31:0] add_sat;
  logic [31:0] in_fix;
  logic [31:0] inside_cnt;
  logic        out_free;
  logic        out_load;

  assign accept   = in_tvalid && in_tready;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign out_free = !out_valid_r || out_tready;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_FACTOR) ? {28'd0, factor_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= FACTOR_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == REG_FACTOR)) begin
      factor_r <= cfg_pwdata[FACTOR_W-1:0];
    end
  end

  bgc_gate_store #(.GATES(GATES)) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en_i   (store_rd),
    .rd_addr_i (GW'(in_tdata[4:0])),
    .wr_i      (store_wr),
    .wr_addr_i (GW'(gate_r)),
    .a_lat_o   (st_a),
    .b_lat_o   (st_b),
    .start_o   (st_start)
  );

  bgc_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_q)
  );

  // gate evaluation
  always_comb begin
    la     = st_a;
    lb     = st_b;
    st_new = st_start;
    if (!a_r && !b_r) begin
      la     = 1'b0;
      lb     = 1'b0;
      st_new = 32'd0;
    end
    if (a_r && !la) begin
      la     = 1'b1;
      st_new = now_r;
    end
    if (b_r && !lb) begin
      lb     = 1'b1;
      st_new = now_r;
    end
    pass    = la && lb && (a_r != b_r);
    dur_nxt = now_r - st_new;
  end

  // passage arithmetic
  always_comb begin
    limit      = 36'(factor_r) * 36'(avg_r);
    is_long    = (avg_r != 32'd0) && ({4'd0, dur_r} > limit);
    single_nxt = (single_r == MAX32) ? single_r : single_r + 32'd1;
    sum_ext    = {1'b0, sum_r} + {17'd0, dur_r};
    sum_nxt    = sum_ext[48] ? MAX48 : sum_ext[47:0];
    q_sat      = (div_q[47:32] != 16'd0) ? MAX32 : div_q[31:0];
    n_cnt      = long_r ? div_q[31:0] : 32'd1;
    add_ext    = a_r ? ({1'b0, out_tot_r} + {1'b0, n_cnt})
                     : ({1'b0, in_tot_r} + {1'b0, n_cnt});
    add_sat    = add_ext[32] ? MAX32 : add_ext[31:0];
    in_fix     = (out_tot_r > in_tot_r) ? out_tot_r : in_tot_r;
    inside_cnt = in_fix - out_tot_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_EVAL;
      ST_EVAL:   state_nxt = (in_range_r && pass) ? ST_CMP : ST_FINISH;
      ST_CMP:    state_nxt = ST_DIV;
      ST_DIV:    if (div_done) state_nxt = ST_APPLY;
      ST_APPLY:  state_nxt = ST_FINISH;
      ST_FINISH: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready        = 1'b0;
    store_rd         = 1'b0;
    store_wr.en      = 1'b0;
    store_wr.a_lat   = la && !pass;
    store_wr.b_lat   = lb && !pass;
    store_wr.start   = st_new;
    div_req.start    = 1'b0;
    div_req.steps    = is_long ? DIV_STEPS_PASS : DIV_STEPS_AVG;
    div_req.dividend = is_long ? {dur_r, 16'd0} : sum_nxt;
    div_req.divisor  = is_long ? avg_r : single_nxt;
    out_load         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        store_rd  = in_tvalid;
      end
      ST_EVAL:   store_wr.en = in_range_r;
      ST_CMP:    div_req.start = 1'b1;
      ST_DIV:    ;
      ST_APPLY:  ;
      ST_FINISH: out_load = out_free;
      default:   ;
    endcase
  end

  always_comb begin
    in_tot_nxt  = in_tot_r;
    out_tot_nxt = out_tot_r;
    if (state_r == ST_APPLY) begin
      if (a_r) out_tot_nxt = add_sat;
      else     in_tot_nxt  = add_sat;
    end else if (out_load) begin
      in_tot_nxt = in_fix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      in_tot_r    <= '0;
      out_tot_r   <= '0;
      single_r    <= '0;
      sum_r       <= '0;
      avg_r       <= '0;
      prev_r      <= '0;
    end else begin
      state_r   <= state_nxt;
      in_tot_r  <= in_tot_nxt;
      out_tot_r <= out_tot_nxt;
      if (state_r == ST_CMP && !is_long) begin
        single_r <= single_nxt;
        sum_r    <= sum_nxt;
      end
      if (state_r == ST_APPLY && !long_r) begin
        avg_r <= q_sat;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        prev_r      <= inside_cnt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      gate_r     <= in_tdata[4:0];
      a_r        <= in_tdata[5];
      b_r        <= in_tdata[6];
      now_r      <= in_tdata[38:7];
      in_range_r <= {27'd0, in_tdata[4:0]} < 32'(GATES);
    end
    if (state_r == ST_EVAL) begin
      dur_r <= dur_nxt;
    end
    if (state_r == ST_CMP) begin
      long_r <= is_long;
    end
    if (out_load) begin
      out_data_r <= {7'd0, (inside_cnt != prev_r), avg_r, inside_cnt, out_tot_r, in_fix};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// testbench for the bidirectional gate counter: directed and random beam samples, scoreboard
module tb_top;
  import bgc_pkg::*;

  localparam int GATES = GATES_DEF;
  localparam logic [CFG_AW-1:0] FACTOR_ADDR = CFG_AW'(4 * REG_FACTOR);
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_PRINTED = 50;

  typedef struct {
    logic [31:0] in_count;
    logic [31:0] out_count;
    logic [31:0] inside_count;
    logic [31:0] mean_duration;
    logic        count_changed;
  } tally_t;

  typedef enum {
    WALK_PLAIN,
    WALK_JOINT_RISE,
    WALK_COLLIDE
  } walk_style_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  // gate counter model state
  bit                beam_a_held [GATES];
  bit                beam_b_held [GATES];
  logic [31:0]       rise_ms [GATES];
  logic [31:0]       inward_sum = '0;
  logic [31:0]       outward_sum = '0;
  logic [31:0]       single_count = '0;
  logic [47:0]       duration_total = '0;
  logic [31:0]       mean_ms = '0;
  logic [31:0]       last_inside = '0;
  logic [FACTOR_W-1:0] gate_factor = FACTOR_RESET;

  tally_t      expected_tallies [$];
  logic [31:0] ms_now = '0;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          hold_request = 0;
  int          hold_left = 0;
  int          samples_sent = 0;
  int          passages_seen = 0;
  int          results_checked = 0;
  int          error_count = 0;
  int          quiet_cycles = 0;

  bidirectional_gate_counter_unit #(.GATES(GATES)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < MAX_PRINTED)
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic logic [31:0] sat_add(input logic [31:0] x, input logic [31:0] y);
    logic [32:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[32] ? MAX32 : s[31:0];
  endfunction

  function automatic tally_t predict_tally(input logic [4:0] g, input logic a, input logic b,
                                           input logic [31:0] t);
    tally_t r;
    logic [31:0] dur;
    logic [31:0] n;
    logic [63:0] lim;
    logic [63:0] acc;
    logic [47:0] quo;
    if (int'(g) < GATES) begin
      if (!a && !b) begin
        beam_a_held[g] = 1'b0;
        beam_b_held[g] = 1'b0;
        rise_ms[g] = '0;
      end
      if (a && !beam_a_held[g]) begin
        beam_a_held[g] = 1'b1;
        rise_ms[g] = t;
      end
      if (b && !beam_b_held[g]) begin
        beam_b_held[g] = 1'b1;
        rise_ms[g] = t;
      end
      if (beam_a_held[g] && beam_b_held[g] && (a != b)) begin
        dur = t - rise_ms[g];
        lim = 64'(gate_factor) * 64'(mean_ms);
        if (mean_ms != 0 && 64'(dur) > lim) begin
          n = dur / mean_ms;
        end else begin
          if (single_count != MAX32)
            single_count++;
          acc = 64'(duration_total) + 64'(dur);
          duration_total = (acc > 64'(MAX48)) ? MAX48 : acc[47:0];
          quo = duration_total / 48'(single_count);
          mean_ms = (quo > 48'(MAX32)) ? MAX32 : quo[31:0];
          n = 32'd1;
        end
        if (!a)
          inward_sum = sat_add(inward_sum, n);
        else
          outward_sum = sat_add(outward_sum, n);
        beam_a_held[g] = 1'b0;
        beam_b_held[g] = 1'b0;
        passages_seen++;
      end
    end
    if (outward_sum > inward_sum)
      inward_sum = outward_sum;
    r.in_count = inward_sum;
    r.out_count = outward_sum;
    r.inside_count = inward_sum - outward_sum;
    r.mean_duration = mean_ms;
    r.count_changed = (r.inside_count != last_inside);
    last_inside = r.inside_count;
    return r;
  endfunction

  function automatic logic [31:0] advance_ms(input int unsigned step);
    ms_now += step;
    return ms_now;
  endfunction

  task automatic send_sample(input logic [4:0] g, input logic a, input logic b,
                             input logic [31:0] t);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, t, b, a, g};
    do @(posedge clk); while (!in_tready);
    expected_tallies.push_back(predict_tally(g, a, b, t));
    samples_sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_tallies.size() != 0)
      @(posedge clk);
  endtask

  task automatic apb_write(input logic [CFG_AW-1:0] addr, input logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == FACTOR_ADDR)
      gate_factor = data[FACTOR_W-1:0];
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read_check(input logic [CFG_AW-1:0] addr, input logic [31:0] want);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want)
      report_mismatch("factor readback", cfg_prdata, want);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_factor(input logic [FACTOR_W-1:0] value);
    drain_results();
    apb_write(FACTOR_ADDR, 32'(value));
  endtask

  // inward: a rises, both held, a drops; outward mirrors it on b
  task automatic walk_passage(input logic [4:0] g, input bit inward, input logic [31:0] dur,
                              input walk_style_t style, input bit lead_clear);
    if (lead_clear)
      send_sample(g, 1'b0, 1'b0, advance_ms(1));
    if (style == WALK_JOINT_RISE) begin
      send_sample(g, 1'b1, 1'b1, advance_ms($urandom_range(0, 5)));
    end else begin
      send_sample(g, inward, !inward, advance_ms($urandom_range(0, 5)));
      send_sample(g, 1'b1, 1'b1, advance_ms($urandom_range(0, 5)));
    end
    if (style == WALK_COLLIDE)
      send_sample(g, 1'b0, 1'b0, advance_ms(dur));
    else
      send_sample(g, !inward, inward, advance_ms(dur));
  endtask

  task automatic test_register_access();
    apb_read_check(FACTOR_ADDR, 32'(FACTOR_RESET));
    apb_write(FACTOR_ADDR, 32'd15);
    apb_read_check(FACTOR_ADDR, 32'd15);
    apb_write(FACTOR_ADDR, 32'(FACTOR_RESET));
    apb_read_check(FACTOR_ADDR, 32'(FACTOR_RESET));
  endtask

  task automatic test_first_passages();
    // outward first: no average yet, ins pulled up to outs
    walk_passage(5'd0, 1'b0, 32'd12, WALK_PLAIN, 1'b0);
    walk_passage(5'd31, 1'b1, 32'd20, WALK_JOINT_RISE, 1'b0);
    // timestamp wraps during the passage
    ms_now = 32'hFFFF_FFF0;
    walk_passage(5'd17, 1'b1, 32'h20, WALK_PLAIN, 1'b0);
    drain_results();
  endtask

  task automatic test_gate_clearing();
    walk_passage(5'd3, 1'b1, 32'd9, WALK_COLLIDE, 1'b0);
    send_sample(5'd4, 1'b1, 1'b0, advance_ms(2));
    send_sample(5'd4, 1'b0, 1'b0, advance_ms(3));
    drain_results();
  endtask

  task automatic test_long_passages();
    set_factor(4'd15);
    walk_passage(5'd8, 1'b1, 15 * mean_ms + 1, WALK_PLAIN, 1'b0);
    set_factor(4'd1);
    walk_passage(5'd8, 1'b0, 3 * mean_ms + 1, WALK_PLAIN, 1'b0);
    set_factor(4'd0);
    walk_passage(5'd9, 1'b1, (mean_ms > 1) ? mean_ms / 2 : 32'd1, WALK_PLAIN, 1'b0);
    walk_passage(5'd9, 1'b0, 32'd0, WALK_PLAIN, 1'b0);
    set_factor(FACTOR_RESET);
  endtask

  task automatic run_random_traffic(input int n_samples);
    int stop_at;
    int pick;
    logic [4:0] g;
    logic [31:0] dur;
    walk_style_t style;
    stop_at = samples_sent + n_samples;
    while (samples_sent < stop_at) begin
      g = 5'($urandom_range(31));
      if ($urandom_range(99) < 25) begin
        send_sample(g, 1'($urandom_range(1)), 1'($urandom_range(1)),
                    advance_ms($urandom_range(0, 3)));
      end else begin
        if ($urandom_range(99) < 15)
          dur = gate_factor * mean_ms + $urandom_range(1, 100);
        else
          dur = $urandom_range(1, 40);
        pick = $urandom_range(99);
        style = (pick < 10) ? WALK_JOINT_RISE : (pick < 20) ? WALK_COLLIDE : WALK_PLAIN;
        walk_passage(g, bit'($urandom_range(1)), dur, style, bit'($urandom_range(1)));
      end
    end
  endtask

  task automatic test_random_traffic();
    set_factor(4'd1);
    gap_pct = 0;
    stall_pct = 0;
    run_random_traffic(70);
    set_factor(4'd15);
    gap_pct = 49;
    run_random_traffic(70);
    set_factor(4'($urandom_range(2, 14)));
    gap_pct = 0;
    stall_pct = 49;
    run_random_traffic(70);
    set_factor(4'($urandom_range(1, 15)));
    gap_pct = 30;
    stall_pct = 30;
    run_random_traffic(70);
    drain_results();
  endtask

  task automatic test_input_backpressure();
    gap_pct = 0;
    stall_pct = 0;
    hold_request = 1;
    repeat (12)
      send_sample(5'($urandom_range(31)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  advance_ms(2));
    drain_results();
  endtask

  task automatic test_counter_saturation();
    int rounds;
    set_factor(4'd1);
    gap_pct = 10;
    stall_pct = 10;
    rounds = 0;
    while (inward_sum != MAX32 && rounds < 400) begin
      walk_passage(5'd21, 1'b1, MAX32, WALK_PLAIN, 1'b1);
      rounds++;
    end
    rounds = 0;
    while (outward_sum != MAX32 && rounds < 400) begin
      walk_passage(5'd22, 1'b0, MAX32, WALK_PLAIN, 1'b1);
      rounds++;
    end
    walk_passage(5'd23, 1'b1, 32'd1, WALK_PLAIN, 1'b1);
    walk_passage(5'd24, 1'b0, 32'd1, WALK_PLAIN, 1'b1);
    drain_results();
  endtask

  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = HOLD_CYCLES;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    tally_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_tallies.size() == 0) begin
        report_mismatch("unexpected result in_count", out_tdata[31:0], '0);
      end else begin
        want = expected_tallies.pop_front();
        if (out_tdata[31:0] !== want.in_count)
          report_mismatch("in_count", out_tdata[31:0], want.in_count);
        if (out_tdata[63:32] !== want.out_count)
          report_mismatch("out_count", out_tdata[63:32], want.out_count);
        if (out_tdata[95:64] !== want.inside_count)
          report_mismatch("inside_count", out_tdata[95:64], want.inside_count);
        if (out_tdata[127:96] !== want.mean_duration)
          report_mismatch("mean_duration", out_tdata[127:96], want.mean_duration);
        if (out_tdata[128] !== want.count_changed)
          report_mismatch("count_changed", 32'(out_tdata[128]), 32'(want.count_changed));
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    ms_now = $urandom;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_access();
    test_first_passages();
    test_gate_clearing();
    test_long_passages();
    test_random_traffic();
    test_input_backpressure();
    test_counter_saturation();
    while (expected_tallies.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
    $display("covered %0d samples and %0d passages: factors 0, 1, 4, 15 and random,",
             samples_sent, passages_seen);
    $display("idle and stall mixes, a long output hold, counter saturation; %0d results checked",
             results_checked);
    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
